### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion macros shared by the header line extractor modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every edge out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at an edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

### hdl/hle_pkg.sv
// ---------------------------------------------------------------------------
// hle_pkg
// constants and controller/datapath interface types for the line extractor
// ---------------------------------------------------------------------------
package hle_pkg;

    localparam int MAX_LEN = 64;
    localparam int AW      = $clog2(MAX_LEN);
    localparam int CW      = $clog2(MAX_LEN + 1);

    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_NL = 8'h0A;

    typedef struct packed {
        logic clr_count;
        logic store;
        logic start_rd;
        logic next_rd;
    } hle_cmd_t;

    typedef struct packed {
        logic is_o;
        logic is_l;
        logic is_d;
        logic is_sp;
        logic is_nl;
        logic full;
        logic last_beat;
    } hle_sts_t;

endpackage

### hdl/hle_ram.sv
// ---------------------------------------------------------------------------
// hle_ram
// generic single write port ram with a registered read port
// ---------------------------------------------------------------------------
module hle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

### hdl/hle_dp.sv
// ---------------------------------------------------------------------------
// hle_dp
// datapath: byte compare, line buffer, fill count and replay pointer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hle_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          rx_byte,
    input  hle_pkg::hle_cmd_t   cmd,
    output hle_pkg::hle_sts_t   sts,
    output logic [7:0]          line_byte,
    output logic                line_end
);

    logic [hle_pkg::CW-1:0] count_reg;
    logic [hle_pkg::CW-1:0] count_next;
    logic [hle_pkg::AW-1:0] idx_reg;
    logic [hle_pkg::AW-1:0] idx_next;
    logic [hle_pkg::AW-1:0] last_reg;
    logic [hle_pkg::AW-1:0] last_next;
    logic                   end_reg;
    logic                   end_next;
    logic                   rd_en;
    logic [hle_pkg::AW-1:0] rd_addr;
    logic [hle_pkg::AW-1:0] idx_inc;

    assign idx_inc = idx_reg + hle_pkg::AW'(1);
    assign rd_en   = cmd.start_rd | cmd.next_rd;
    assign rd_addr = cmd.start_rd ? '0 : idx_inc;

    always_comb
    begin
        count_next = count_reg;
        last_next  = last_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        else if (cmd.store)
        begin
            count_next = count_reg + hle_pkg::CW'(1);
            last_next  = count_reg[hle_pkg::AW-1:0];
        end
        if (rd_en)
        begin
            idx_next = rd_addr;
            end_next = (rd_addr == last_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            last_reg  <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
            end_reg   <= end_next;
        end
    end

    hle_ram #(
        .WIDTH (8),
        .DEPTH (hle_pkg::MAX_LEN)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (count_reg[hle_pkg::AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (line_byte)
    );

    assign sts.is_o      = (rx_byte == hle_pkg::CH_O);
    assign sts.is_l      = (rx_byte == hle_pkg::CH_L);
    assign sts.is_d      = (rx_byte == hle_pkg::CH_D);
    assign sts.is_sp     = (rx_byte == hle_pkg::CH_SP);
    assign sts.is_nl     = (rx_byte == hle_pkg::CH_NL);
    assign sts.full      = (count_reg == hle_pkg::CW'(hle_pkg::MAX_LEN));
    assign sts.last_beat = end_reg;

    assign line_end = end_reg;

    `ASSERT_CLK(a_count_bound, clk, rst_n, count_reg <= hle_pkg::CW'(hle_pkg::MAX_LEN), "line count past buffer size")
    `ASSERT_NEVER(a_store_when_full, clk, rst_n, cmd.store && sts.full, "store into a full line buffer")

endmodule

### hdl/hle_ctrl.sv
// ---------------------------------------------------------------------------
// hle_ctrl
// controller: header matcher, payload collection and line replay sequencing
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hle_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    output logic              line_valid,
    input  logic              line_ready,
    input  hle_pkg::hle_sts_t sts,
    output hle_pkg::hle_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_O    = 3'd1;
    localparam logic [2:0] ST_OL   = 3'd2;
    localparam logic [2:0] ST_OLD  = 3'd3;
    localparam logic [2:0] ST_BODY = 3'd4;
    localparam logic [2:0] ST_READ = 3'd5;
    localparam logic [2:0] ST_SEND = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rx_beat;

    assign rx_ready   = (state_reg != ST_READ) && (state_reg != ST_SEND);
    assign line_valid = (state_reg == ST_SEND);
    assign rx_beat    = rx_valid && rx_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_beat)
                begin
                    state_next = sts.is_o ? ST_O : ST_IDLE;
                end
            end
            ST_O:
            begin
                if (rx_beat)
                begin
                    state_next = sts.is_l ? ST_OL : ST_IDLE;
                end
            end
            ST_OL:
            begin
                if (rx_beat)
                begin
                    state_next = sts.is_d ? ST_OLD : ST_IDLE;
                end
            end
            ST_OLD:
            begin
                if (rx_beat)
                begin
                    if (sts.is_sp)
                    begin
                        cmd.clr_count = 1'b1;
                        state_next    = ST_BODY;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BODY:
            begin
                if (rx_beat)
                begin
                    if (sts.full)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                        if (sts.is_nl)
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                // first buffer read, in the cycle after the newline write
                cmd.start_rd = 1'b1;
                state_next   = ST_SEND;
            end
            ST_SEND:
            begin
                if (line_ready)
                begin
                    if (sts.last_beat)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_rd = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEVER(a_no_dual_beat, clk, rst_n, rx_ready && line_valid, "input and output open together")
    `ASSERT_CLK(a_nl_starts_replay, clk, rst_n, (state_reg == ST_BODY && rx_beat && sts.is_nl && !sts.full) |=> (state_reg == ST_READ), "newline did not start replay")
    `ASSERT_CLK(a_last_ends_replay, clk, rst_n, (line_valid && line_ready && sts.last_beat) |=> (state_reg == ST_IDLE), "replay ran past the newline")

endmodule

### hdl/header_line_extractor.sv
// ---------------------------------------------------------------------------
// header_line_extractor
// header and payload bytes are taken one per cycle while rx_valid is high; input is held off
// in replay; a newline leads to a buffer read state, then the line replays from the buffer at
// one beat per cycle while line_ready is high; reset idles the matcher, buffer data undefined
// ---------------------------------------------------------------------------
module header_line_extractor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       line_valid,
    input  logic       line_ready,
    output logic [7:0] line_byte,
    output logic       line_end
);

    hle_pkg::hle_cmd_t cmd;
    hle_pkg::hle_sts_t sts;

    hle_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    hle_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_byte   (rx_byte),
        .cmd       (cmd),
        .sts       (sts),
        .line_byte (line_byte),
        .line_end  (line_end)
    );

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for header_line_extractor: bytes are pushed through the
// rx channel in random bursts, a software copy of the header matcher and line
// buffer predicts each replayed line, and every line beat is compared in order
// ---------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_BYTES = 100;

    typedef enum logic [2:0] {
        HDR_IDLE,
        HDR_O,
        HDR_OL,
        HDR_OLD,
        HDR_BODY
    } hdr_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } line_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte = 8'h00;
    logic       line_valid;
    logic       line_ready = 1'b0;
    logic [7:0] line_byte;
    logic       line_end;

    // predicted matcher state
    hdr_phase_t hdr_phase = HDR_IDLE;
    int         held_len = 0;
    logic [7:0] held_line [hle_pkg::MAX_LEN];

    line_beat_t pending_beats [$];
    line_beat_t due_beat;
    int         fail_count = 0;
    int         cycles = 0;
    int         bytes_sent = 0;
    int         burst_left = 0;
    bit         idle_en = 1'b1;
    int         stall_left = 0;
    int         stall_odds = 0;

    header_line_extractor i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line_byte  (line_byte),
        .line_end   (line_end)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d beats outstanding", $time, pending_beats.size());
            $display("tb failed");
            $finish;
        end
    end

    // receiver stalls, with the stall odds drawn at random from four settings
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            line_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            line_ready <= 1'b1;
            if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds)
                stall_left <= $urandom_range(1, 6);
        end
        if (cycles % 256 == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_odds <= 0;
                1: stall_odds <= 10;
                2: stall_odds <= 40;
                default: stall_odds <= 70;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && line_valid && line_ready)
        begin
            if (pending_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got byte %02h end %b",
                         $time, line_byte, line_end);
                fail_count++;
            end
            else
            begin
                due_beat = pending_beats.pop_front();
                if (line_byte !== due_beat.data)
                begin
                    $display("%0t: line_byte expected %02h got %02h",
                             $time, due_beat.data, line_byte);
                    fail_count++;
                end
                if (line_end !== due_beat.last)
                begin
                    $display("%0t: line_end expected %b got %b",
                             $time, due_beat.last, line_end);
                    fail_count++;
                end
            end
        end
    end

    // naive header match, then buffer payload and replay it on newline
    task automatic track_byte(input logic [7:0] b);
        line_beat_t beat;
        case (hdr_phase)
            HDR_O:   hdr_phase = (b == hle_pkg::CH_L) ? HDR_OL : HDR_IDLE;
            HDR_OL:  hdr_phase = (b == hle_pkg::CH_D) ? HDR_OLD : HDR_IDLE;
            HDR_OLD:
            begin
                if (b == hle_pkg::CH_SP)
                begin
                    held_len  = 0;
                    hdr_phase = HDR_BODY;
                end
                else
                    hdr_phase = HDR_IDLE;
            end
            HDR_BODY:
            begin
                if (held_len >= hle_pkg::MAX_LEN)
                    hdr_phase = HDR_IDLE;
                else
                begin
                    held_line[held_len] = b;
                    held_len++;
                    if (b == hle_pkg::CH_NL)
                    begin
                        for (int k = 0; k < held_len; k++)
                        begin
                            beat.data = held_line[k];
                            beat.last = (k + 1 == held_len);
                            pending_beats.push_back(beat);
                        end
                        hdr_phase = HDR_IDLE;
                    end
                end
            end
            default: hdr_phase = (b == hle_pkg::CH_O) ? HDR_O : HDR_IDLE;
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_en)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 10);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        bytes_sent++;
        track_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_payload();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == hle_pkg::CH_NL);
        return b;
    endfunction

    task automatic send_payload(input int len);
        for (int i = 0; i < len; i++)
            send_byte(rand_payload());
    endtask

    // hold the sender off until every predicted beat has come out
    task automatic drain_lines();
        rx_valid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_basic_lines();
        send_text("OLD hello\n");
        send_text("OLD \n");
        send_text("OLD ab\n");
    endtask

    task automatic test_header_mismatch();
        send_text("OX");
        send_text("OL\n");
        send_text("OLDX");
        // second O is dropped, the rest is seen from idle
        send_text("OOLD \n");
        // O in place of the space is dropped too
        send_text("OLDOLD \n");
        send_text("OLD a\n");
    endtask

    task automatic test_byte_extremes();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("OLD ");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(hle_pkg::CH_NL);
    endtask

    task automatic test_buffer_limits();
        // longest line that fits, newline in the last slot
        send_text("OLD ");
        send_payload(hle_pkg::MAX_LEN - 1);
        send_byte(hle_pkg::CH_NL);
        // full buffer: the newline is dropped and nothing comes out
        send_text("OLD ");
        send_payload(hle_pkg::MAX_LEN);
        send_byte(hle_pkg::CH_NL);
        send_text("X\n");
        // full buffer again, the dropped byte could have started a header
        send_text("OLD ");
        send_payload(hle_pkg::MAX_LEN);
        send_text("OLD \n");
        send_text("OLD ok\n");
    endtask

    task automatic test_random_lines();
        int         kind;
        int         len;
        int         cut;
        int         start;
        int         next_pause;
        string      hdr;
        logic [7:0] b;
        hdr        = "OLD ";
        start      = bytes_sent;
        next_pause = start + 50;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            idle_en = ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 19);
            if (kind < 3)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else if (kind < 6)
            begin
                // header broken at a random point
                cut = $urandom_range(0, 3);
                for (int i = 0; i < cut; i++)
                    send_byte(hdr[i]);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == hdr[cut]);
                send_byte(b);
            end
            if (kind == 19)
                len = $urandom_range(40, hle_pkg::MAX_LEN + 2);
            else
                len = $urandom_range(0, 12);
            send_text(hdr);
            send_payload(len);
            send_byte(hle_pkg::CH_NL);
            if (bytes_sent >= next_pause)
            begin
                drain_lines();
                next_pause = bytes_sent + 50;
            end
        end
        idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_lines();
        test_header_mismatch();
        test_byte_extremes();
        test_buffer_limits();
        drain_lines();
        test_random_lines();

        rx_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/hle_pkg.sv
hdl/hle_ram.sv
hdl/hle_dp.sv
hdl/hle_ctrl.sv
hdl/header_line_extractor.sv
tb/tb.sv
